/* hw/rtl/ccpb_pkg.sv */
`default_nettype none

package ccpb_pkg;

    // Palette index that is never drawn
    localparam logic [7:0] TRANSPARENT_INDEX = 8'd255;

    // Input opcodes (carried on the slave-side tuser)
    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_PIXEL   = 1'b1;

    // Register indexes, byte address = 4 * index
    localparam logic [2:0] REG_SCREEN_W = 3'd0;
    localparam logic [2:0] REG_SCREEN_H = 3'd1;
    localparam logic [2:0] REG_DEST_X   = 3'd2;
    localparam logic [2:0] REG_DEST_Y   = 3'd3;
    localparam logic [2:0] REG_WIN_W    = 3'd4;
    localparam logic [2:0] REG_WIN_H    = 3'd5;

    localparam int CFG_W = 13;

    // Palette port request
    typedef struct packed {
        logic        wr_en;
        logic [7:0]  wr_addr;
        logic [15:0] wr_data;
        logic        rd_en;
        logic [7:0]  rd_addr;
    } t_pal_req;

endpackage

`default_nettype wire

/* hw/rtl/ccpb_palette.sv */
`default_nettype none

module ccpb_palette
    import ccpb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_pal_req    i_req,
    output logic [15:0]      o_rdata
);

    logic [15:0] r_mem [256];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/clipped_color_keyed_palette_blit.sv */
// Clipped, color-keyed palette blit.
//
// Slave stream: one word per item. tuser = opcode (0 palette load, 1 pixel).
// A palette load stores a 16-bit color and gives no output word. A pixel is
// placed at (dest_x + column, dest_y + row) of the window, raster order, and
// gives one master word: write enable (0 when clipped or index 255), screen
// position, palette color and tlast on the final pixel of the window. Pixels
// of a window lying wholly off screen give no word but still advance.
//
// APB port: six 13-bit registers at 0x00..0x14 (screen w/h, dest x/y,
// window w/h). Any register write restarts the window. Write only when idle.
//
// Throughput: one item per clock while the master side is not stalled. A pixel
// passes the position/clip stage with the palette read, then the output
// register. A stall on the master side is absorbed by the two stages; the
// slave keeps accepting until both are full.
// Reset clears counters, pipeline valids and registers to their defaults;
// palette contents are undefined until loaded, no clearing pass is run.

`default_nettype none

module clipped_color_keyed_palette_blit
    import ccpb_pkg::*;
#(
    parameter int MAX_COORD = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [7:0] pixel_index, [15:8] palette_address, [31:16] palette_color
    input  wire logic [31:0] i_s_axis_tdata,
    // [0] opcode
    input  wire logic        i_s_axis_tuser,

    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [11:0] screen_x, [23:12] screen_y, [39:24] color
    output logic [39:0]      o_m_axis_tdata,
    // [0] write_enable
    output logic             o_m_axis_tuser,
    output logic             o_m_axis_tlast,

    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [4:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready
);

    localparam int CW  = $clog2(MAX_COORD);           // counter width
    localparam int SZW = CW + 1;                      // clamped size width
    localparam int AW  = ((SZW > CFG_W) ? SZW : CFG_W) + 2;

    function automatic logic [SZW-1:0] clamp_size(input logic [CFG_W-1:0] v);
        if (32'(v) > MAX_COORD) begin
            return SZW'(MAX_COORD);
        end
        return SZW'(v);
    endfunction

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] r_screen_w, r_screen_h, r_dest_x, r_dest_y, r_win_w, r_win_h;
    logic             cfg_wr;
    logic             cfg_hit;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel & i_penable & i_pwrite;
    assign cfg_hit  = cfg_wr && (i_paddr[4:2] <= REG_WIN_H);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w <= CFG_W'(640);
            r_screen_h <= CFG_W'(480);
            r_dest_x   <= '0;
            r_dest_y   <= '0;
            r_win_w    <= CFG_W'(8);
            r_win_h    <= CFG_W'(8);
        end else if (cfg_wr) begin
            case (i_paddr[4:2])
                REG_SCREEN_W: r_screen_w <= i_pwdata[CFG_W-1:0];
                REG_SCREEN_H: r_screen_h <= i_pwdata[CFG_W-1:0];
                REG_DEST_X:   r_dest_x   <= i_pwdata[CFG_W-1:0];
                REG_DEST_Y:   r_dest_y   <= i_pwdata[CFG_W-1:0];
                REG_WIN_W:    r_win_w    <= i_pwdata[CFG_W-1:0];
                REG_WIN_H:    r_win_h    <= i_pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[4:2])
            REG_SCREEN_W: o_prdata = 32'(r_screen_w);
            REG_SCREEN_H: o_prdata = 32'(r_screen_h);
            REG_DEST_X:   o_prdata = 32'(r_dest_x);
            REG_DEST_Y:   o_prdata = 32'(r_dest_y);
            REG_WIN_W:    o_prdata = 32'(r_win_w);
            REG_WIN_H:    o_prdata = 32'(r_win_h);
            default:      o_prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    logic r_s1_v, r_out_v;
    logic s_accept, s1_move, m_take;

    assign o_s_axis_tready = !r_s1_v || !r_out_v || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign s1_move         = r_s1_v && (!r_out_v || i_m_axis_tready);
    assign m_take          = r_out_v && i_m_axis_tready;

    logic       in_pixel;
    logic [7:0] in_index;
    assign in_pixel = s_accept && (i_s_axis_tuser == OP_PIXEL);
    assign in_index = i_s_axis_tdata[7:0];

    // ---------------- position and clipping ----------------
    logic [SZW-1:0] sw, sh, ww, wh;
    logic [SZW-1:0] col_ext, row_ext, col_c, row_c;
    logic [CW-1:0]  r_col, r_row, n_col, n_row;
    logic           size_zero, row_end, win_last, off, visible, opaque, emit;
    logic signed [AW-1:0] s_sw, s_sh, s_ww, s_wh, s_dx, s_dy, s_x, s_y;

    always_comb begin
        sw = clamp_size(r_screen_w);
        sh = clamp_size(r_screen_h);
        ww = clamp_size(r_win_w);
        wh = clamp_size(r_win_h);
        s_sw = AW'($signed({1'b0, sw}));
        s_sh = AW'($signed({1'b0, sh}));
        s_ww = AW'($signed({1'b0, ww}));
        s_wh = AW'($signed({1'b0, wh}));
        s_dx = AW'($signed(r_dest_x));
        s_dy = AW'($signed(r_dest_y));

        size_zero = (ww == '0) || (wh == '0);
        col_ext   = SZW'(r_col);
        row_ext   = SZW'(r_row);
        col_c     = (col_ext >= ww) ? ww - 1'b1 : col_ext;
        row_c     = (row_ext >= wh) ? wh - 1'b1 : row_ext;
        row_end   = (col_c == ww - 1'b1);
        win_last  = row_end && (row_c == wh - 1'b1);

        off = (sw == '0) || (sh == '0) || (s_dx >= s_sw) || (s_dy >= s_sh) ||
              (s_dx + s_ww <= 0) || (s_dy + s_wh <= 0);

        s_x = s_dx + AW'($signed({1'b0, col_c}));
        s_y = s_dy + AW'($signed({1'b0, row_c}));
        visible = !s_x[AW-1] && (s_x < s_sw) && !s_y[AW-1] && (s_y < s_sh);
        opaque  = (in_index != TRANSPARENT_INDEX);
        emit    = in_pixel && !size_zero && !off;

        n_col = r_col;
        n_row = r_row;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (in_pixel) begin
            if (size_zero) begin
                n_col = '0;
                n_row = '0;
            end else if (row_end) begin
                n_col = '0;
                n_row = win_last ? '0 : CW'(row_c + 1'b1);
            end else begin
                n_col = CW'(col_c + 1'b1);
                n_row = CW'(row_c);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- palette ----------------
    t_pal_req    pal_req;
    logic [15:0] pal_rdata;

    always_comb begin
        pal_req.wr_en   = s_accept && (i_s_axis_tuser == OP_PALETTE);
        pal_req.wr_addr = i_s_axis_tdata[15:8];
        pal_req.wr_data = i_s_axis_tdata[31:16];
        pal_req.rd_en   = emit;
        pal_req.rd_addr = in_index;
    end

    ccpb_palette u_palette (
        .i_clk   (i_clk),
        .i_req   (pal_req),
        .o_rdata (pal_rdata)
    );

    // ---------------- stage 1 ----------------
    logic        r_s1_we, r_s1_last;
    logic [11:0] r_s1_x, r_s1_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s_accept) begin
            r_s1_v <= emit;
        end else if (s1_move) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_we   <= visible && opaque;
            r_s1_x    <= (visible && opaque) ? s_x[11:0] : '0;
            r_s1_y    <= (visible && opaque) ? s_y[11:0] : '0;
            r_s1_last <= win_last;
        end
    end

    // ---------------- output register ----------------
    logic        r_out_we, r_out_last;
    logic [11:0] r_out_x, r_out_y;
    logic [15:0] r_out_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_move) begin
            r_out_v <= 1'b1;
        end else if (m_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_we    <= r_s1_we;
            r_out_x     <= r_s1_x;
            r_out_y     <= r_s1_y;
            r_out_color <= r_s1_we ? pal_rdata : '0;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {r_out_color, r_out_y, r_out_x};
    assign o_m_axis_tuser  = r_out_we;
    assign o_m_axis_tlast  = r_out_last;

    // ---------------- assertions ----------------
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> (r_col == '0) && (r_row == '0))
        else $error("register write did not restart the window");

    a_col_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ww != '0) |-> (SZW'(r_col) < ww))
        else $error("column counter beyond window width");

    a_zero_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        size_zero |-> (r_col == '0) && (r_row == '0))
        else $error("counters moved on an empty window");

    a_masked_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out_we) |-> (o_m_axis_tdata == '0))
        else $error("masked word carries position or color");

endmodule

`default_nettype wire
